// ===== design/gbc_pkg.sv =====
package gbc_pkg;

  localparam int unsigned RATE_W  = 16;
  localparam int unsigned VAL_W   = 24;
  localparam int unsigned CNT_W   = 20;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned LIM_W   = 23;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W   = 23;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd5;

  localparam logic [CNT_W-1:0]  SETTLE_RST = 20'd2500;
  localparam logic [CNT_W-1:0]  MAX_RST    = 20'd15000;
  localparam logic [STEP_W-1:0] STEP_RST   = 16'd26;
  localparam logic [LIM_W-1:0]  CLAMP_RST  = 23'd204800;
  localparam logic [LIM_W-1:0]  MARGIN_RST = 23'd25600;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd131;

  // calibration phase codes
  localparam logic [STAT_W-1:0] PH_IDLE    = 2'd0;
  localparam logic [STAT_W-1:0] PH_RUN     = 2'd1;
  localparam logic [STAT_W-1:0] PH_DONE    = 2'd2;
  localparam logic [STAT_W-1:0] PH_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0]  settle;
    logic [CNT_W-1:0]  max_cnt;
    logic [STEP_W-1:0] step;
    logic [LIM_W-1:0]  clamp;
    logic [LIM_W-1:0]  margin;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic load;  // copy bias into tracker
    logic upd;   // run tracker and filter on this sample
    logic clr;   // zero the bias (timeout)
  } lane_ctl_t;

endpackage

// ===== design/gbc_lane.sv =====
module gbc_lane import gbc_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic signed [RATE_W-1:0] rate_i,
  input  lane_ctl_t                ctl_i,
  output logic                     moved_o,
  output logic signed [VAL_W-1:0]  bias_d_o
);

  localparam int unsigned SW = RATE_W + FRAC_BITS;
  localparam int unsigned EW = (SW > VAL_W) ? SW : VAL_W;
  localparam int unsigned TW = VAL_W + 3;
  localparam int unsigned PW = VAL_W + 1 + GAIN_W + 1;
  localparam logic signed [PW-1:0] ROUND = PW'(1) <<< (GAIN_W - 1);

  logic signed [VAL_W-1:0] trk_q, trk_d;
  logic signed [VAL_W-1:0] bias_q;

  logic signed [EW-1:0]    ext;
  logic signed [VAL_W-1:0] smp;
  logic signed [TW-1:0]    s_w, t0, t1, t2, t3, stp, lim;
  logic signed [TW-1:0]    abs_s, abs_t, thr;
  logic signed [VAL_W:0]   diff;
  logic signed [PW-1:0]    prod, rnd;
  logic signed [VAL_W+1:0] dd, sum;
  logic signed [VAL_W-1:0] filt;

  // scale to fixed point and saturate to the value range
  assign ext = EW'(rate_i) <<< FRAC_BITS;

  always_comb begin
    if ((&ext[EW-1:VAL_W-1]) || !(|ext[EW-1:VAL_W-1])) begin
      smp = ext[VAL_W-1:0];
    end else if (ext[EW-1]) begin
      smp = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      smp = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  assign s_w = TW'(smp);
  assign t0  = TW'(trk_q);
  assign stp = signed'(TW'(cfg_i.step));
  assign lim = signed'(TW'(cfg_i.clamp));

  // two sequential step checks, then clamp
  always_comb begin
    t1 = (s_w > t0) ? t0 + stp : t0;
    t2 = (s_w < t1) ? t1 - stp : t1;
    if (t2 > lim) begin
      t3 = lim;
    end else if (t2 < -lim) begin
      t3 = -lim;
    end else begin
      t3 = t2;
    end
  end

  assign trk_d = t3[VAL_W-1:0];

  assign abs_s = s_w[TW-1] ? -s_w : s_w;
  assign abs_t = t3[TW-1] ? -t3 : t3;
  assign thr   = signed'(TW'(cfg_i.margin)) + abs_t;
  assign moved_o = abs_s > thr;

  // low-pass: step rounded to nearest, never past the sample
  assign diff = (VAL_W+1)'(smp) - (VAL_W+1)'(bias_q);
  assign prod = PW'(diff) * signed'(PW'(cfg_i.gain));
  assign rnd  = prod + ROUND;
  assign dd   = rnd[PW-1:GAIN_W];
  assign sum  = (VAL_W+2)'(bias_q) + dd;
  assign filt = sum[VAL_W-1:0];

  always_comb begin
    bias_d_o = bias_q;
    if (ctl_i.upd && !moved_o) begin
      bias_d_o = filt;
    end
    if (ctl_i.clr) begin
      bias_d_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q  <= '0;
      bias_q <= '0;
    end else begin
      bias_q <= bias_d_o;
      if (ctl_i.load) begin
        trk_q <= bias_q;
      end else if (ctl_i.upd) begin
        trk_q <= trk_d;
      end
    end
  end

endmodule

// ===== design/gbc_merge.sv =====
module gbc_merge import gbc_pkg::*; #(
  parameter int unsigned AXES = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              accept_i,
  input  logic              mode_i,
  input  logic [AXES-1:0]   moved_i,
  output lane_ctl_t         ctl_o,
  output logic [STAT_W-1:0] phase_d_o
);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic [STAT_W-1:0] phase_q;
  logic [CNT_W-1:0]  quiet_q, quiet_d, total_q, total_d;
  logic [CNT_W-1:0]  quiet_n, total_n;
  logic              start, go, done, tout;

  assign start = accept_i && !mode_i;
  assign go    = accept_i && mode_i && (phase_q == PH_RUN);

  assign total_n = (total_q == CNT_MAX) ? total_q : total_q + 1'b1;
  assign quiet_n = (|moved_i) ? '0 :
                   ((quiet_q == CNT_MAX) ? quiet_q : quiet_q + 1'b1);

  // still wins over timeout when both land on the same sample
  assign done = quiet_n >= cfg_i.settle;
  assign tout = !done && (total_n >= cfg_i.max_cnt);

  assign ctl_o.load = start;
  assign ctl_o.upd  = go;
  assign ctl_o.clr  = go && tout;

  always_comb begin
    phase_d_o = phase_q;
    quiet_d   = quiet_q;
    total_d   = total_q;
    if (start) begin
      phase_d_o = PH_RUN;
      quiet_d   = '0;
      total_d   = '0;
    end else if (go) begin
      quiet_d = quiet_n;
      total_d = total_n;
      if (done) begin
        phase_d_o = PH_DONE;
      end else if (tout) begin
        phase_d_o = PH_TIMEOUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      quiet_q <= '0;
      total_q <= '0;
    end else begin
      phase_q <= phase_d_o;
      quiet_q <= quiet_d;
      total_q <= total_d;
    end
  end

endmodule

// ===== design/gyro_bias_calibrator.sv =====
// Gyro bias calibrator.
// Input stream: one transaction per loop period. tuser selects the kind:
// 0 starts a calibration (copies the bias into the trackers, clears the
// counters), 1 carries a raw x/y/z rate sample in tdata. Every accepted
// input transaction yields exactly one output transaction carrying the
// three bias values (8 fraction bits by default) and the calibration status:
// idle, running, done still, or timed out with the bias zeroed.
// One lane per axis steps the tracker, checks for motion and filters the
// bias; a merge stage combines the motion flags and runs the quiet and total
// sample counters. The whole update for a sample is combinational.
// The result is registered and appears in the cycle after acceptance.
// One transaction per cycle unless stalled, set by the single output register;
// input ready stays high while that register is empty or being drained.
// When the receiver stalls, the pending result holds and input ready drops.
// Reset clears the bias, trackers, counters and phase (idle) and loads the
// default configuration. Configuration writes take effect on the next clock;
// the user must make them with no transaction in flight (not enforced here).
module gyro_bias_calibrator import gbc_pkg::*; #(
  parameter int unsigned AXES      = 3,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [47:0]          s_axis_tdata_i,  // rate_x, rate_y, rate_z
  input  logic [0:0]           s_axis_tuser_i,  // mode
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [79:0]          m_axis_tdata_o,  // bias_x, bias_y, bias_z, status, zero pad
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t              cfg_q;
  lane_ctl_t         ctl;
  logic [AXES-1:0]   moved;
  logic [STAT_W-1:0] phase_d;
  logic              accept;

  logic signed [VAL_W-1:0] bias_nx [3];
  logic signed [VAL_W-1:0] bias_q  [3];
  logic [STAT_W-1:0]       stat_q;
  logic                    out_vld_q;

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle  <= SETTLE_RST;
      cfg_q.max_cnt <= MAX_RST;
      cfg_q.step    <= STEP_RST;
      cfg_q.clamp   <= CLAMP_RST;
      cfg_q.margin  <= MARGIN_RST;
      cfg_q.gain    <= GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SETTLE: cfg_q.settle  <= cfg_data_i[CNT_W-1:0];
        REG_MAX:    cfg_q.max_cnt <= cfg_data_i[CNT_W-1:0];
        REG_STEP:   cfg_q.step    <= cfg_data_i[STEP_W-1:0];
        REG_CLAMP:  cfg_q.clamp   <= cfg_data_i[LIM_W-1:0];
        REG_MARGIN: cfg_q.margin  <= cfg_data_i[LIM_W-1:0];
        REG_GAIN:   cfg_q.gain    <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    if (i < AXES) begin : g_lane
      gbc_lane #(
        .FRAC_BITS(FRAC_BITS)
      ) u_lane (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .cfg_i   (cfg_q),
        .rate_i  (s_axis_tdata_i[i*RATE_W +: RATE_W]),
        .ctl_i   (ctl),
        .moved_o (moved[i]),
        .bias_d_o(bias_nx[i])
      );
    end else begin : g_none
      assign bias_nx[i] = '0;
    end
  end

  gbc_merge #(
    .AXES(AXES)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .mode_i   (s_axis_tuser_i[0]),
    .moved_i  (moved),
    .ctl_o    (ctl),
    .phase_d_o(phase_d)
  );

  // output register: load on each accepted transaction, drain on ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (accept) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bias_q[0] <= bias_nx[0];
      bias_q[1] <= bias_nx[1];
      bias_q[2] <= bias_nx[2];
      stat_q    <= phase_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'b0, stat_q, bias_q[2], bias_q[1], bias_q[0]};

endmodule
